// File: hdl/rpl_osp_pkg.sv
`default_nettype none
package rpl_osp_pkg;

	// limits
	localparam logic [6:0]  MAX_NESTING   = 7'd64;
	localparam int          STACK_DEPTH   = 65;
	localparam logic [20:0] SPACE_NIBBLES = 21'h100000;

	// frame kinds held in the frame memory
	localparam logic [1:0] FRAME_LIST = 2'd1;
	localparam logic [1:0] FRAME_WRAP = 2'd2;

	// prologs
	localparam logic [19:0] PR_BINT     = 20'h02911;
	localparam logic [19:0] PR_REAL     = 20'h02933;
	localparam logic [19:0] PR_EREAL    = 20'h02955;
	localparam logic [19:0] PR_CMPLX    = 20'h02977;
	localparam logic [19:0] PR_ECMPLX   = 20'h0299d;
	localparam logic [19:0] PR_CHR      = 20'h029bf;
	localparam logic [19:0] PR_ARRAY    = 20'h029e8;
	localparam logic [19:0] PR_LNKARRAY = 20'h02a0a;
	localparam logic [19:0] PR_STRING   = 20'h02a2c;
	localparam logic [19:0] PR_HXS      = 20'h02a4e;
	localparam logic [19:0] PR_LIST     = 20'h02a74;
	localparam logic [19:0] PR_DIR      = 20'h02a96;
	localparam logic [19:0] PR_SYMB     = 20'h02ab8;
	localparam logic [19:0] PR_UNIT     = 20'h02ada;
	localparam logic [19:0] PR_TAGGED   = 20'h02afc;
	localparam logic [19:0] PR_GROB     = 20'h02b1e;
	localparam logic [19:0] PR_LIB      = 20'h02b40;
	localparam logic [19:0] PR_BACKUP   = 20'h02b62;
	localparam logic [19:0] PR_LIBDATA  = 20'h02b88;
	localparam logic [19:0] PR_ACCPTR   = 20'h02baa;
	localparam logic [19:0] PR_RES2     = 20'h02bcc;
	localparam logic [19:0] PR_RES3     = 20'h02bee;
	localparam logic [19:0] PR_RES4     = 20'h02c10;
	localparam logic [19:0] PR_PROGRAM  = 20'h02d9d;
	localparam logic [19:0] PR_CODE     = 20'h02dcc;
	localparam logic [19:0] PR_GNAME    = 20'h02e48;
	localparam logic [19:0] PR_LNAME    = 20'h02e6d;
	localparam logic [19:0] PR_ROMPTR   = 20'h02e92;
	localparam logic [19:0] PR_END      = 20'h0312b;

	// control sequencer
	typedef enum logic [4:0] {
		ST_RUN  = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_URD  = 5'b00100,
		ST_UCHK = 5'b01000,
		ST_EMIT = 5'b10000
	} ctl_state_t;

	// parse phase
	typedef enum logic [10:0] {
		PH_PROLOG     = 11'b00000000001,
		PH_SKIP_END   = 11'b00000000010,
		PH_SKIP_CHILD = 11'b00000000100,
		PH_SIZE       = 11'b00000001000,
		PH_TAGLEN     = 11'b00000010000,
		PH_IDLEN      = 11'b00000100000,
		PH_DIR_PAD    = 11'b00001000000,
		PH_DIR_OFS    = 11'b00010000000,
		PH_DIR_GAP    = 11'b00100000000,
		PH_DIR_NAME   = 11'b01000000000,
		PH_IDLE       = 11'b10000000000
	} phase_t;

	function automatic logic is_composite(input logic [19:0] p);
		return (p == PR_LIST) || (p == PR_SYMB) || (p == PR_UNIT) || (p == PR_PROGRAM);
	endfunction

	function automatic logic is_sized(input logic [19:0] p);
		return (p == PR_ARRAY) || (p == PR_LNKARRAY) || (p == PR_STRING) ||
			(p == PR_HXS) || (p == PR_GROB) || (p == PR_LIB) || (p == PR_BACKUP) ||
			(p == PR_LIBDATA) || (p == PR_RES2) || (p == PR_RES3) || (p == PR_RES4) ||
			(p == PR_CODE);
	endfunction

	// total length of fixed-size objects, pointer length otherwise
	function automatic logic [5:0] fixed_len(input logic [19:0] p);
		logic [5:0] len;
		unique case (p)
			PR_BINT:   len = 6'd10;
			PR_REAL:   len = 6'd21;
			PR_EREAL:  len = 6'd26;
			PR_CMPLX:  len = 6'd37;
			PR_ECMPLX: len = 6'd47;
			PR_CHR:    len = 6'd7;
			PR_ROMPTR: len = 6'd11;
			PR_ACCPTR: len = 6'd15;
			default:   len = 6'd5;
		endcase
		return len;
	endfunction

	// room for a new prolog at this depth and position
	function automatic logic begin_ok(input logic [6:0] lvl, input logic [20:0] pos,
			input logic [20:0] av);
		return (lvl <= MAX_NESTING) && (({2'b0, pos} + 23'd5) <= {2'b0, av});
	endfunction

endpackage
`default_nettype wire

// File: hdl/rpl_object_size_parser.sv
`default_nettype none
// Object size walker: nibbles of a stored object arrive one item at a time (start_object
// on the first), and one result (size, bad flag) leaves when the object completes or
// proves malformed. A plain nibble is accepted in RUN, executed in EXEC. A nibble that
// ends an object or child then walks the stack: each frame examined takes a read of the
// frame-kind memory (one read port, registered read data) in URD, then a check in UCHK,
// plus a final URD visit if the stack empties. A result is registered as pending, then
// loaded into the output register in EMIT. A result waiting in the output register
// blocks new nibbles only once the next result is due and out_ready is still low.
// The frame memory needs no clearing: only entries below the current level are read.
module rpl_object_size_parser (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [20:0] available_nibbles,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [3:0]  nibble,
	input  wire         start_object,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [20:0] size_nibbles,
	output logic        bad_object
);

	rpl_osp_pkg::ctl_state_t state_q, state_d;
	rpl_osp_pkg::phase_t     phase_q, phase_d;
	logic [6:0]  level_q, level_d;
	logic [19:0] shift_q, shift_d;
	logic [19:0] fa_q, fa_d;
	logic [20:0] skip_q, skip_d;
	logic [20:0] cons_q, cons_d;
	logic        fin_q, fin_d;
	logic        term_q, term_d;
	logic [20:0] av_q;
	logic [3:0]  nib_s1;
	logic        start_s1;
	logic [20:0] res_size_q;
	logic        res_bad_q;
	logic        out_valid_q;
	logic [20:0] out_size_q;
	logic        out_bad_q;

	logic [1:0]  mem_q [0:rpl_osp_pkg::STACK_DEPTH-1];
	logic [1:0]  rdata_q;
	logic        mem_we;
	logic [6:0]  mem_waddr;
	logic [1:0]  mem_wkind;
	logic        rd_en;

	logic        emit;
	logic        emit_bad;
	logic [20:0] emit_size;

	assign cfg_ready      = 1'b1;
	assign in_ready       = (state_q == rpl_osp_pkg::ST_RUN);
	assign out_valid      = out_valid_q;
	assign size_nibbles   = out_size_q;
	assign bad_object     = out_bad_q;
	assign rd_en          = (state_q == rpl_osp_pkg::ST_URD) && (level_q != 7'd0);

	// next-state logic: one nibble in EXEC, stack unwinding in URD/UCHK
	always_comb begin
		rpl_osp_pkg::phase_t e_ph;
		logic [6:0]  e_lvl;
		logic [20:0] e_cons, e_skp, pos, cnt;
		logic [19:0] e_shf, e_fa, v;
		logic        e_fin, go_unw, unw_term, w5;
		logic [2:0]  pk;
		logic [8:0]  v2;
		logic [5:0]  fl;

		state_d = state_q; phase_d = phase_q; level_d = level_q; shift_d = shift_q;
		fa_d = fa_q; skip_d = skip_q; cons_d = cons_q; fin_d = fin_q; term_d = term_q;
		mem_we = 1'b0; mem_waddr = level_q; mem_wkind = rpl_osp_pkg::FRAME_LIST;
		emit = 1'b0; emit_bad = 1'b0; emit_size = cons_q;
		e_ph = phase_q; e_lvl = level_q; e_cons = cons_q; e_skp = skip_q;
		e_shf = shift_q; e_fa = fa_q; e_fin = fin_q; go_unw = 1'b0; unw_term = 1'b0;
		w5 = 1'b0; pk = 3'd0; v2 = 9'd0; fl = 6'd0; pos = cons_q; cnt = 21'd0; v = fa_q;

		unique case (state_q)
			rpl_osp_pkg::ST_RUN: begin
				if (in_valid) state_d = rpl_osp_pkg::ST_EXEC;
			end
			rpl_osp_pkg::ST_EXEC: begin
				// start clears parse state and opens the top object when the space check passes
				if (start_s1) begin
					e_lvl = 7'd0; e_cons = 21'd0; e_fa = 20'd0; e_skp = 21'd0;
					e_fin = 1'b0; e_ph = rpl_osp_pkg::PH_IDLE;
					if (av_q > rpl_osp_pkg::SPACE_NIBBLES ||
							!rpl_osp_pkg::begin_ok(7'd0, 21'd0, av_q)) begin
						emit = 1'b1; emit_bad = 1'b1;
					end else begin
						e_ph = rpl_osp_pkg::PH_PROLOG; e_skp = 21'd5; e_shf = 20'd0;
					end
				end
				if (!emit && !e_fin && e_ph != rpl_osp_pkg::PH_IDLE && e_skp != 21'd0) begin
					pos = e_cons + 21'd1;
					e_cons = pos;
					w5 = (e_ph == rpl_osp_pkg::PH_SIZE) || (e_ph == rpl_osp_pkg::PH_DIR_OFS);
					pk = (e_ph == rpl_osp_pkg::PH_PROLOG || w5) ? 3'd5 - e_skp[2:0]
						: 3'd2 - e_skp[2:0];
					e_skp = e_skp - 21'd1;
					case (e_ph)
						rpl_osp_pkg::PH_PROLOG: begin
							e_shf = e_shf | ({16'd0, nib_s1} << {pk, 2'b00});
							if (e_skp == 21'd0) begin
								if (rpl_osp_pkg::is_composite(e_shf)) begin
									if (e_lvl <= rpl_osp_pkg::MAX_NESTING) begin
										mem_we = 1'b1; mem_waddr = e_lvl;
										mem_wkind = rpl_osp_pkg::FRAME_LIST;
										e_lvl = e_lvl + 7'd1;
									end
									if (rpl_osp_pkg::begin_ok(e_lvl, pos, av_q)) begin
										e_ph = rpl_osp_pkg::PH_PROLOG; e_skp = 21'd5;
										e_shf = 20'd0;
									end else begin
										emit = 1'b1; emit_bad = 1'b1;
									end
								end else if (e_shf == rpl_osp_pkg::PR_END) begin
									go_unw = 1'b1; unw_term = 1'b1;
								end else if (e_shf == rpl_osp_pkg::PR_TAGGED ||
										e_shf == rpl_osp_pkg::PR_GNAME ||
										e_shf == rpl_osp_pkg::PR_LNAME) begin
									if ({2'b0, pos} + 23'd2 > {2'b0, av_q}) begin
										emit = 1'b1; emit_bad = 1'b1;
									end else begin
										e_ph = (e_shf == rpl_osp_pkg::PR_TAGGED) ?
											rpl_osp_pkg::PH_TAGLEN : rpl_osp_pkg::PH_IDLEN;
										e_skp = 21'd2; e_fa = 20'd0;
									end
								end else if (e_shf == rpl_osp_pkg::PR_DIR) begin
									if ({2'b0, pos} + 23'd8 > {2'b0, av_q}) begin
										emit = 1'b1; emit_bad = 1'b1;
									end else begin
										e_ph = rpl_osp_pkg::PH_DIR_PAD; e_skp = 21'd3;
									end
								end else if (rpl_osp_pkg::is_sized(e_shf)) begin
									if ({2'b0, pos} + 23'd5 > {2'b0, av_q}) begin
										emit = 1'b1; emit_bad = 1'b1;
									end else begin
										e_ph = rpl_osp_pkg::PH_SIZE; e_skp = 21'd5;
										e_fa = 20'd0;
									end
								end else begin
									fl = rpl_osp_pkg::fixed_len(e_shf);
									if ({2'b0, pos} + {17'd0, fl} > {2'b0, av_q} + 23'd5) begin
										emit = 1'b1; emit_bad = 1'b1;
									end else if (fl == 6'd5) begin
										go_unw = 1'b1;
									end else begin
										e_ph = rpl_osp_pkg::PH_SKIP_END;
										e_skp = {15'd0, fl} - 21'd5;
									end
								end
							end
						end
						rpl_osp_pkg::PH_SIZE, rpl_osp_pkg::PH_TAGLEN, rpl_osp_pkg::PH_IDLEN,
						rpl_osp_pkg::PH_DIR_OFS, rpl_osp_pkg::PH_DIR_NAME: begin
							e_fa = e_fa | ({16'd0, nib_s1} << {pk, 2'b00});
							v = e_fa;
							v2 = {v[7:0], 1'b0};
							if (e_skp == 21'd0) begin
								case (e_ph)
									rpl_osp_pkg::PH_SIZE: begin
										if (v < 20'd5 || {2'b0, pos} + {3'd0, v} >
												{2'b0, av_q} + 23'd5) begin
											emit = 1'b1; emit_bad = 1'b1;
										end else begin
											cnt = {1'b0, v} - 21'd5;
											if (cnt == 21'd0) go_unw = 1'b1;
											else begin
												e_ph = rpl_osp_pkg::PH_SKIP_END; e_skp = cnt;
											end
										end
									end
									rpl_osp_pkg::PH_IDLEN: begin
										if ({2'b0, pos} + {14'd0, v2} > {2'b0, av_q}) begin
											emit = 1'b1; emit_bad = 1'b1;
										end else if (v2 == 9'd0) begin
											go_unw = 1'b1;
										end else begin
											e_ph = rpl_osp_pkg::PH_SKIP_END;
											e_skp = {12'd0, v2};
										end
									end
									rpl_osp_pkg::PH_DIR_OFS: begin
										if (v == 20'd0) begin
											go_unw = 1'b1;
										end else if (v < 20'd5 || {2'b0, pos} + {3'd0, v} >
												{2'b0, av_q} + 23'd3) begin
											emit = 1'b1; emit_bad = 1'b1;
										end else begin
											cnt = {1'b0, v} - 21'd5;
											if (cnt == 21'd0) begin
												e_ph = rpl_osp_pkg::PH_DIR_NAME; e_skp = 21'd2;
												e_fa = 20'd0;
											end else begin
												e_ph = rpl_osp_pkg::PH_DIR_GAP; e_skp = cnt;
											end
										end
									end
									default: begin
										// tag length or directory name length: one child follows
										cnt = (e_ph == rpl_osp_pkg::PH_TAGLEN) ? {12'd0, v2}
											: {12'd0, v2} + 21'd2;
										if ({2'b0, pos} + {2'b0, cnt} > {2'b0, av_q}) begin
											emit = 1'b1; emit_bad = 1'b1;
										end else begin
											if (e_lvl <= rpl_osp_pkg::MAX_NESTING) begin
												mem_we = 1'b1; mem_waddr = e_lvl;
												mem_wkind = rpl_osp_pkg::FRAME_WRAP;
												e_lvl = e_lvl + 7'd1;
											end
											if (cnt != 21'd0) begin
												e_ph = rpl_osp_pkg::PH_SKIP_CHILD; e_skp = cnt;
											end else if (rpl_osp_pkg::begin_ok(e_lvl, pos,
													av_q)) begin
												e_ph = rpl_osp_pkg::PH_PROLOG; e_skp = 21'd5;
												e_shf = 20'd0;
											end else begin
												emit = 1'b1; emit_bad = 1'b1;
											end
										end
									end
								endcase
							end
						end
						default: begin
							// plain skip phases
							if (e_skp == 21'd0) begin
								case (e_ph)
									rpl_osp_pkg::PH_SKIP_END: go_unw = 1'b1;
									rpl_osp_pkg::PH_SKIP_CHILD: begin
										if (rpl_osp_pkg::begin_ok(e_lvl, pos, av_q)) begin
											e_ph = rpl_osp_pkg::PH_PROLOG; e_skp = 21'd5;
											e_shf = 20'd0;
										end else begin
											emit = 1'b1; emit_bad = 1'b1;
										end
									end
									rpl_osp_pkg::PH_DIR_PAD: begin
										e_ph = rpl_osp_pkg::PH_DIR_OFS; e_skp = 21'd5;
										e_fa = 20'd0;
									end
									default: begin
										e_ph = rpl_osp_pkg::PH_DIR_NAME; e_skp = 21'd2;
										e_fa = 20'd0;
									end
								endcase
							end
						end
					endcase
				end
				phase_d = e_ph; level_d = e_lvl; cons_d = e_cons; skip_d = e_skp;
				shift_d = e_shf; fa_d = e_fa; fin_d = e_fin; term_d = unw_term;
				state_d = go_unw ? rpl_osp_pkg::ST_URD : rpl_osp_pkg::ST_RUN;
			end
			rpl_osp_pkg::ST_URD: begin
				// empty stack closes the top object
				if (level_q == 7'd0) begin
					emit = 1'b1;
					emit_size = term_q ? cons_q - 21'd5 : cons_q;
				end else begin
					state_d = rpl_osp_pkg::ST_UCHK;
				end
			end
			rpl_osp_pkg::ST_UCHK: begin
				if (rdata_q == rpl_osp_pkg::FRAME_WRAP) begin
					level_d = level_q - 7'd1;
					state_d = rpl_osp_pkg::ST_URD;
				end else if (term_q) begin
					// terminator closes this list, which then ends as an object
					level_d = level_q - 7'd1;
					term_d = 1'b0;
					state_d = rpl_osp_pkg::ST_URD;
				end else if (rpl_osp_pkg::begin_ok(level_q, cons_q, av_q)) begin
					phase_d = rpl_osp_pkg::PH_PROLOG; skip_d = 21'd5; shift_d = 20'd0;
					state_d = rpl_osp_pkg::ST_RUN;
				end else begin
					emit = 1'b1; emit_bad = 1'b1;
				end
			end
			rpl_osp_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) state_d = rpl_osp_pkg::ST_RUN;
			end
			default: state_d = rpl_osp_pkg::ST_RUN;
		endcase

		if (emit) begin
			fin_d = 1'b1;
			phase_d = rpl_osp_pkg::PH_IDLE;
			state_d = rpl_osp_pkg::ST_EMIT;
		end
	end

	// control and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpl_osp_pkg::ST_RUN;
			phase_q <= rpl_osp_pkg::PH_IDLE;
			level_q <= 7'd0;
			shift_q <= 20'd0;
			fa_q    <= 20'd0;
			skip_q  <= 21'd0;
			cons_q  <= 21'd0;
			fin_q   <= 1'b1;
			term_q  <= 1'b0;
			av_q    <= 21'd0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			level_q <= level_d;
			shift_q <= shift_d;
			fa_q    <= fa_d;
			skip_q  <= skip_d;
			cons_q  <= cons_d;
			fin_q   <= fin_d;
			term_q  <= term_d;
			if (cfg_valid) av_q <= available_nibbles;
		end
	end

	// accepted item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			nib_s1   <= nibble;
			start_s1 <= start_object;
		end
	end

	// pending result, size forced to zero when bad
	always_ff @(posedge clk) begin
		if (emit) begin
			res_size_q <= emit_bad ? 21'd0 : emit_size;
			res_bad_q  <= emit_bad;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rpl_osp_pkg::ST_EMIT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rpl_osp_pkg::ST_EMIT && (!out_valid_q || out_ready)) begin
			out_size_q <= res_size_q;
			out_bad_q  <= res_bad_q;
		end
	end

	// frame-kind memory
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wkind;
		if (rd_en) rdata_q <= mem_q[level_q - 7'd1];
	end

	// stack never grows past one frame above the nesting limit
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= rpl_osp_pkg::MAX_NESTING + 7'd1)
		else $error("frame level out of range");

	// frame check only follows a read of a live entry
	a_read_before_check: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rpl_osp_pkg::ST_UCHK |->
			$past(state_q == rpl_osp_pkg::ST_URD) && level_q != 7'd0)
		else $error("frame check without read");

	// a bad result never carries a size
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_bad_q |-> out_size_q == 21'd0)
		else $error("bad result with nonzero size");

	// parser is finished whenever a result is being handed out
	a_emit_finished: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rpl_osp_pkg::ST_EMIT |-> fin_q && phase_q == rpl_osp_pkg::PH_IDLE)
		else $error("result while parse active");

endmodule
`default_nettype wire
